### sv/diff_drive_odometry_assert.svh
// ----------------------------------------------------------------------------
// Differential drive odometry assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH
// same-cycle implication
`define DDO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("odometry check failed");
// next-cycle implication
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("odometry check failed");
`endif

### sv/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Types, constants and helper functions of the wheel odometry block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int PROD_W = 68;
  localparam int COR_W  = 34;
  localparam int DIV_W  = 52;
  localparam int DVSR_W = 32;

  localparam logic signed [COR_W-1:0] CORDIC_GAIN    = 34'sd652032874;
  localparam logic signed [COR_W-1:0] HALF_PI_Q30    = 34'sd1686629713;
  localparam logic signed [COR_W-1:0] INV_TWO_PI_Q32 = 34'sd683565276;
  localparam logic signed [COR_W-1:0] MICRO          = 34'sd1000000;

  localparam logic signed [PROD_W-1:0] RND_17  = 68'sd65536;
  localparam logic signed [PROD_W-1:0] RND_30  = 68'sd536870912;
  localparam logic signed [PROD_W-1:0] S32_MAX = 68'sd2147483647;
  localparam logic signed [PROD_W-1:0] S32_MIN = -68'sd2147483648;

  localparam logic signed [COR_W-1:0] QUAT_RND = 34'sd8192;
  localparam logic signed [COR_W-1:0] QUAT_MAX = 34'sd65536;
  localparam logic signed [COR_W-1:0] QUAT_MIN = -34'sd65536;

  localparam logic [0:0] REG_RADIUS     = 1'b0;
  localparam logic [0:0] REG_SEPARATION = 1'b1;

  localparam logic [15:0] RADIUS_RESET     = 16'd2163;
  localparam logic [17:0] SEPARATION_RESET = 18'd11141;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_DS,
    OP_MUL_DTH,
    OP_DIV_SEP,
    OP_HEAD,
    OP_MUL_PH,
    OP_MZ_PH,
    OP_COR_START,
    OP_MUL_X,
    OP_MUL_Y,
    OP_POSE_Y,
    OP_MZ_HALF,
    OP_QUAT,
    OP_MUL_LIN,
    OP_DIV_DT,
    OP_LIN,
    OP_MUL_ANG,
    OP_ANG,
    OP_OUT
  } ddo_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_DS,
    ST_MUL_DTH,
    ST_DIV_DTH,
    ST_WAIT_DTH,
    ST_MUL_PH,
    ST_MZ_PH,
    ST_COR_PH,
    ST_WAIT_PH,
    ST_MUL_Y,
    ST_POSE_Y,
    ST_MZ_HALF,
    ST_COR_HALF,
    ST_WAIT_HALF,
    ST_MUL_LIN,
    ST_DIV_LIN,
    ST_WAIT_LIN,
    ST_MUL_ANG,
    ST_DIV_ANG,
    ST_WAIT_ANG,
    ST_OUT
  } ddo_state_e;

  typedef struct packed {
    ddo_op_e op;
  } ddo_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cor_done;
    logic out_free;
  } ddo_status_t;

  function automatic logic signed [COR_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [COR_W-1:0] v;
    unique case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      5'd24: v = 34'sd64;
      5'd25: v = 34'sd32;
      5'd26: v = 34'sd16;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] ext32(input logic signed [31:0] v);
    return {{(PROD_W-32){v[31]}}, v};
  endfunction

  function automatic logic signed [17:0] to_quat(input logic signed [COR_W-1:0] v);
    logic signed [COR_W-1:0] q;
    q = (v + QUAT_RND) >>> 14;
    if (q > QUAT_MAX) begin
      q = QUAT_MAX;
    end else if (q < QUAT_MIN) begin
      q = QUAT_MIN;
    end
    return q[17:0];
  endfunction

endpackage

### sv/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ddo_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ddo_pkg::DIV_W-1:0]   dividend_i,
  input  logic [ddo_pkg::DVSR_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [ddo_pkg::DIV_W-1:0]   quotient_o
);

  localparam int CNT_W = $clog2(ddo_pkg::DIV_W + 1);

  logic                        busy_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [ddo_pkg::DIV_W-1:0]   dvd_q;
  logic [ddo_pkg::DVSR_W-1:0]  dvsr_q;
  logic [ddo_pkg::DVSR_W-1:0]  rem_q;
  logic [ddo_pkg::DVSR_W:0]    rem_sh;
  logic [ddo_pkg::DVSR_W:0]    rem_sub;
  logic                        qbit;

  assign rem_sh  = {rem_q, dvd_q[ddo_pkg::DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr_q};
  assign qbit    = (rem_sh >= {1'b0, dvsr_q});
  assign done_o  = busy_q && (cnt_q == CNT_W'(ddo_pkg::DIV_W));
  assign quotient_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      dvsr_q <= divisor_i;
      rem_q  <= '0;
    end else if (busy_q && !done_o) begin
      dvd_q <= {dvd_q[ddo_pkg::DIV_W-2:0], qbit};
      rem_q <= qbit ? rem_sub[ddo_pkg::DVSR_W-1:0] : rem_sh[ddo_pkg::DVSR_W-1:0];
    end
  end

endmodule

### sv/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, Q30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ddo_cordic #(
  parameter int CORDIC_STEPS = 18
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ddo_pkg::COR_W-1:0]  z0_i,
  output logic                              done_o,
  output logic signed [ddo_pkg::COR_W-1:0]  x_o,
  output logic signed [ddo_pkg::COR_W-1:0]  y_o
);

  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

  logic                              busy_q;
  logic [CNT_W-1:0]                  i_q;
  logic signed [ddo_pkg::COR_W-1:0]  x_q, y_q, z_q;
  logic signed [ddo_pkg::COR_W-1:0]  x_sh, y_sh, ang;
  logic                              dir;

  assign x_sh   = x_q >>> i_q;
  assign y_sh   = y_q >>> i_q;
  assign ang    = ddo_pkg::atan_q30(5'(i_q));
  assign dir    = !z_q[ddo_pkg::COR_W-1];
  assign done_o = busy_q && (i_q == CNT_W'(CORDIC_STEPS));
  assign x_o    = x_q;
  assign y_o    = y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      i_q    <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      i_q <= i_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= ddo_pkg::CORDIC_GAIN;
      y_q <= '0;
      z_q <= z0_i;
    end else if (busy_q && !done_o) begin
      x_q <= dir ? x_q - y_sh : x_q + y_sh;
      y_q <= dir ? y_q + x_sh : y_q - x_sh;
      z_q <= dir ? z_q - ang : z_q + ang;
    end
  end

endmodule

### sv/ddo_dpath.sv
// ----------------------------------------------------------------------------
// ddo_dpath
// Odometry datapath: deltas, shared multiplier, divider, CORDIC, pose state
// and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ddo_dpath #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ddo_pkg::ddo_cmd_t     cmd_i,
  output ddo_pkg::ddo_status_t  status_o,
  input  logic signed [31:0]    left_angle_i,
  input  logic signed [31:0]    right_angle_i,
  input  logic [31:0]           stamp_us_i,
  input  logic [15:0]           radius_i,
  input  logic [17:0]           separation_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic signed [31:0]    pos_x_o,
  output logic signed [31:0]    pos_y_o,
  output logic signed [31:0]    heading_o,
  output logic signed [17:0]    quat_z_o,
  output logic signed [17:0]    quat_w_o,
  output logic signed [31:0]    lin_velocity_o,
  output logic signed [31:0]    ang_velocity_o,
  output logic                  zero_interval_o
);

  localparam int PW = ddo_pkg::PROD_W;
  localparam int CW = ddo_pkg::COR_W;
  localparam int DW = ddo_pkg::DIV_W;

  logic [31:0]           last_l_q, last_r_q, last_st_q;
  logic signed [32:0]    sum_q, diff_q;
  logic [31:0]           dt_q;
  logic signed [31:0]    ds_q, dth_q, heading_q, pose_x_q, pose_y_q, lin_q, ang_q;
  logic [31:0]           half_q;
  logic                  flip_q, neg_q, out_valid_q;
  logic signed [PW-1:0]  prod_q;
  logic signed [17:0]    qz_q, qw_q;

  logic [31:0]           dl, dr, phase_sel, phase_off, t_val;
  logic signed [32:0]    sum_d, diff_d;
  logic                  flip_d, mul_en, div_start, cor_start, out_free;
  logic signed [CW-1:0]  mul_a, mul_b, cor_x, cor_y, cor_c, cor_s;
  logic signed [PW-1:0]  rs17, rs30, prod_abs, q_ext, q_signed;
  logic signed [31:0]    q_sat, dth_d;
  logic [17:0]           sep_eff;
  logic [ddo_pkg::DVSR_W-1:0] divisor;
  logic [DW-1:0]         div_quot;
  logic                  div_done, cor_done;

  assign dl     = left_angle_i - last_l_q;
  assign dr     = right_angle_i - last_r_q;
  assign sum_d  = $signed({dl[31], dl}) + $signed({dr[31], dr});
  assign diff_d = $signed({dr[31], dr}) - $signed({dl[31], dl});

  // quarter-turn fold around the CORDIC range
  assign phase_sel = (cmd_i.op == ddo_pkg::OP_MZ_HALF) ? half_q : prod_q[FRAC_BITS +: 32];
  assign phase_off = phase_sel + 32'h4000_0000;
  assign flip_d    = phase_off[31];
  assign t_val     = flip_d ? phase_sel + 32'h8000_0000 : phase_sel;

  assign cor_c = flip_q ? -cor_x : cor_x;
  assign cor_s = flip_q ? -cor_y : cor_y;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd_i.op)
      ddo_pkg::OP_MUL_DS: begin
        mul_a = {sum_q[32], sum_q};
        mul_b = {18'd0, radius_i};
      end
      ddo_pkg::OP_MUL_DTH: begin
        mul_a = {diff_q[32], diff_q};
        mul_b = {18'd0, radius_i};
      end
      ddo_pkg::OP_MUL_PH: begin
        mul_a = {{2{heading_q[31]}}, heading_q};
        mul_b = ddo_pkg::INV_TWO_PI_Q32;
      end
      ddo_pkg::OP_MZ_PH, ddo_pkg::OP_MZ_HALF: begin
        mul_a = {{2{t_val[31]}}, t_val};
        mul_b = ddo_pkg::HALF_PI_Q30;
      end
      ddo_pkg::OP_MUL_X: begin
        mul_a = {{2{ds_q[31]}}, ds_q};
        mul_b = cor_c;
      end
      ddo_pkg::OP_MUL_Y: begin
        mul_a = {{2{ds_q[31]}}, ds_q};
        mul_b = cor_s;
      end
      ddo_pkg::OP_MUL_LIN: begin
        mul_a = {{2{ds_q[31]}}, ds_q};
        mul_b = ddo_pkg::MICRO;
      end
      ddo_pkg::OP_MUL_ANG: begin
        mul_a = {{2{dth_q[31]}}, dth_q};
        mul_b = ddo_pkg::MICRO;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign rs17 = (prod_q + ddo_pkg::RND_17) >>> 17;
  assign rs30 = (prod_q + ddo_pkg::RND_30) >>> 30;

  assign prod_abs  = prod_q[PW-1] ? -prod_q : prod_q;
  assign sep_eff   = (separation_i == 18'd0) ? 18'd1 : separation_i;
  assign divisor   = (cmd_i.op == ddo_pkg::OP_DIV_SEP) ? {14'd0, sep_eff} : dt_q;
  assign div_start = (cmd_i.op == ddo_pkg::OP_DIV_SEP) || (cmd_i.op == ddo_pkg::OP_DIV_DT);
  assign cor_start = (cmd_i.op == ddo_pkg::OP_COR_START);

  assign q_ext    = {{(PW-DW){1'b0}}, div_quot};
  assign q_signed = neg_q ? -q_ext : q_ext;
  assign q_sat    = ddo_pkg::sat32(q_signed);
  assign dth_d    = q_sat;

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.div_done = div_done;
  assign status_o.cor_done = cor_done;
  assign status_o.out_free = out_free;

  ddo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_abs[DW-1:0]),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .z0_i    (rs30[CW-1:0]),
    .done_o  (cor_done),
    .x_o     (cor_x),
    .y_o     (cor_y)
  );

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q    <= '0;
      last_r_q    <= '0;
      last_st_q   <= '0;
      heading_q   <= '0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == ddo_pkg::OP_LOAD) begin
        last_l_q  <= left_angle_i;
        last_r_q  <= right_angle_i;
        last_st_q <= stamp_us_i;
      end
      if (cmd_i.op == ddo_pkg::OP_HEAD) begin
        heading_q <= ddo_pkg::sat32(ddo_pkg::ext32(heading_q) + ddo_pkg::ext32(dth_d));
      end
      if (cmd_i.op == ddo_pkg::OP_MUL_Y) begin
        pose_x_q <= ddo_pkg::sat32(ddo_pkg::ext32(pose_x_q) + rs30);
      end
      if (cmd_i.op == ddo_pkg::OP_POSE_Y) begin
        pose_y_q <= ddo_pkg::sat32(ddo_pkg::ext32(pose_y_q) + rs30);
      end
      if (cmd_i.op == ddo_pkg::OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= PW'(mul_a) * PW'(mul_b);
    end
    if (div_start) begin
      neg_q <= prod_q[PW-1];
    end
    unique case (cmd_i.op)
      ddo_pkg::OP_LOAD: begin
        sum_q  <= sum_d;
        diff_q <= diff_d;
        dt_q   <= stamp_us_i - last_st_q;
      end
      ddo_pkg::OP_MUL_DTH: ds_q <= ddo_pkg::sat32(rs17);
      ddo_pkg::OP_HEAD:    dth_q <= dth_d;
      ddo_pkg::OP_MZ_PH: begin
        half_q <= prod_q[FRAC_BITS+1 +: 32];
        flip_q <= flip_d;
      end
      ddo_pkg::OP_MZ_HALF: flip_q <= flip_d;
      ddo_pkg::OP_QUAT: begin
        qz_q <= ddo_pkg::to_quat(cor_s);
        qw_q <= ddo_pkg::to_quat(cor_c);
      end
      ddo_pkg::OP_LIN: lin_q <= (dt_q == 32'd0) ? 32'sd0 : q_sat;
      ddo_pkg::OP_ANG: ang_q <= (dt_q == 32'd0) ? 32'sd0 : q_sat;
      ddo_pkg::OP_OUT: begin
        pos_x_o         <= pose_x_q;
        pos_y_o         <= pose_y_q;
        heading_o       <= heading_q;
        quat_z_o        <= qz_q;
        quat_w_o        <= qw_q;
        lin_velocity_o  <= lin_q;
        ang_velocity_o  <= ang_q;
        zero_interval_o <= (dt_q == 32'd0);
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer of the odometry datapath: one command per cycle unless waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ddo_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ddo_pkg::ddo_status_t  status_i,
  output ddo_pkg::ddo_cmd_t     cmd_o
);

  ddo_pkg::ddo_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddo_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = ddo_pkg::OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      ddo_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = ddo_pkg::OP_LOAD;
          state_d  = ddo_pkg::ST_MUL_DS;
        end
      end
      ddo_pkg::ST_MUL_DS: begin
        cmd_o.op = ddo_pkg::OP_MUL_DS;
        state_d  = ddo_pkg::ST_MUL_DTH;
      end
      ddo_pkg::ST_MUL_DTH: begin
        cmd_o.op = ddo_pkg::OP_MUL_DTH;
        state_d  = ddo_pkg::ST_DIV_DTH;
      end
      ddo_pkg::ST_DIV_DTH: begin
        cmd_o.op = ddo_pkg::OP_DIV_SEP;
        state_d  = ddo_pkg::ST_WAIT_DTH;
      end
      ddo_pkg::ST_WAIT_DTH: begin
        if (status_i.div_done) begin
          cmd_o.op = ddo_pkg::OP_HEAD;
          state_d  = ddo_pkg::ST_MUL_PH;
        end
      end
      ddo_pkg::ST_MUL_PH: begin
        cmd_o.op = ddo_pkg::OP_MUL_PH;
        state_d  = ddo_pkg::ST_MZ_PH;
      end
      ddo_pkg::ST_MZ_PH: begin
        cmd_o.op = ddo_pkg::OP_MZ_PH;
        state_d  = ddo_pkg::ST_COR_PH;
      end
      ddo_pkg::ST_COR_PH: begin
        cmd_o.op = ddo_pkg::OP_COR_START;
        state_d  = ddo_pkg::ST_WAIT_PH;
      end
      ddo_pkg::ST_WAIT_PH: begin
        if (status_i.cor_done) begin
          cmd_o.op = ddo_pkg::OP_MUL_X;
          state_d  = ddo_pkg::ST_MUL_Y;
        end
      end
      ddo_pkg::ST_MUL_Y: begin
        cmd_o.op = ddo_pkg::OP_MUL_Y;
        state_d  = ddo_pkg::ST_POSE_Y;
      end
      ddo_pkg::ST_POSE_Y: begin
        cmd_o.op = ddo_pkg::OP_POSE_Y;
        state_d  = ddo_pkg::ST_MZ_HALF;
      end
      ddo_pkg::ST_MZ_HALF: begin
        cmd_o.op = ddo_pkg::OP_MZ_HALF;
        state_d  = ddo_pkg::ST_COR_HALF;
      end
      ddo_pkg::ST_COR_HALF: begin
        cmd_o.op = ddo_pkg::OP_COR_START;
        state_d  = ddo_pkg::ST_WAIT_HALF;
      end
      ddo_pkg::ST_WAIT_HALF: begin
        if (status_i.cor_done) begin
          cmd_o.op = ddo_pkg::OP_QUAT;
          state_d  = ddo_pkg::ST_MUL_LIN;
        end
      end
      ddo_pkg::ST_MUL_LIN: begin
        cmd_o.op = ddo_pkg::OP_MUL_LIN;
        state_d  = ddo_pkg::ST_DIV_LIN;
      end
      ddo_pkg::ST_DIV_LIN: begin
        cmd_o.op = ddo_pkg::OP_DIV_DT;
        state_d  = ddo_pkg::ST_WAIT_LIN;
      end
      ddo_pkg::ST_WAIT_LIN: begin
        if (status_i.div_done) begin
          cmd_o.op = ddo_pkg::OP_LIN;
          state_d  = ddo_pkg::ST_MUL_ANG;
        end
      end
      ddo_pkg::ST_MUL_ANG: begin
        cmd_o.op = ddo_pkg::OP_MUL_ANG;
        state_d  = ddo_pkg::ST_DIV_ANG;
      end
      ddo_pkg::ST_DIV_ANG: begin
        cmd_o.op = ddo_pkg::OP_DIV_DT;
        state_d  = ddo_pkg::ST_WAIT_ANG;
      end
      ddo_pkg::ST_WAIT_ANG: begin
        if (status_i.div_done) begin
          cmd_o.op = ddo_pkg::OP_ANG;
          state_d  = ddo_pkg::ST_OUT;
        end
      end
      ddo_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = ddo_pkg::OP_OUT;
          state_d  = ddo_pkg::ST_IDLE;
        end
      end
      default: state_d = ddo_pkg::ST_IDLE;
    endcase
  end

endmodule

### sv/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential drive wheel odometry with APB configuration registers.
// ----------------------------------------------------------------------------
// One word in, one word out. Each word's time is set by the bit-serial 52-bit
// divider, run three times (heading step, linear and angular velocity), and
// the one-step-a-cycle CORDIC, run twice (heading and half heading), plus
// the wait while a still stalled output word holds back the new one. The
// input stalls from acceptance until the result is moved to the output
// register; a pending output word does not block the next input.
`timescale 1ns / 1ps
module diff_drive_odometry #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] left_angle_i,
  input  logic signed [31:0] right_angle_i,
  input  logic [31:0]        stamp_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  output logic signed [17:0] quat_z_o,
  output logic signed [17:0] quat_w_o,
  output logic signed [31:0] lin_velocity_o,
  output logic signed [31:0] ang_velocity_o,
  output logic               zero_interval_o
);

  logic [15:0]          radius_q;
  logic [17:0]          separation_q;
  logic                 wr_en;
  ddo_pkg::ddo_cmd_t    cmd;
  ddo_pkg::ddo_status_t status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= ddo_pkg::RADIUS_RESET;
      separation_q <= ddo_pkg::SEPARATION_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        ddo_pkg::REG_RADIUS:     radius_q     <= pwdata[15:0];
        ddo_pkg::REG_SEPARATION: separation_q <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ddo_pkg::REG_RADIUS:     prdata = {16'd0, radius_q};
      ddo_pkg::REG_SEPARATION: prdata = {14'd0, separation_q};
      default:                 prdata = '0;
    endcase
  end

  ddo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ddo_dpath #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .left_angle_i    (left_angle_i),
    .right_angle_i   (right_angle_i),
    .stamp_us_i      (stamp_us_i),
    .radius_i        (radius_q),
    .separation_i    (separation_q),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .heading_o       (heading_o),
    .quat_z_o        (quat_z_o),
    .quat_w_o        (quat_w_o),
    .lin_velocity_o  (lin_velocity_o),
    .ang_velocity_o  (ang_velocity_o),
    .zero_interval_o (zero_interval_o)
  );

endmodule

### sv/ddo_checker.sv
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks of the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "diff_drive_odometry_assert.svh"
module ddo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] pos_x_o,
  input logic signed [17:0] quat_z_o,
  input logic signed [17:0] quat_w_o,
  input logic signed [31:0] lin_velocity_o,
  input logic signed [31:0] ang_velocity_o,
  input logic               zero_interval_o
);

  `DDO_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `DDO_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(pos_x_o))
  `DDO_ASSERT_NOW(a_zero_vel, out_valid_o && zero_interval_o, (lin_velocity_o == 32'sd0) && (ang_velocity_o == 32'sd0))
  `DDO_ASSERT_NOW(a_quat_range, out_valid_o, (quat_z_o >= -18'sd65536) && (quat_z_o <= 18'sd65536) && (quat_w_o >= -18'sd65536) && (quat_w_o <= 18'sd65536))

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);
